>>> hdl/trapezoid_step_generator_unit_assert.svh
// Assertion macros shared by the step generator RTL.
`ifndef TRAPEZOID_STEP_GENERATOR_UNIT_ASSERT_SVH
`define TRAPEZOID_STEP_GENERATOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSG_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");
`define TSG_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define TSG_NEVER(lbl, cond)
`define TSG_IMPLIES(lbl, ante, cons)
`endif
`endif

>>> hdl/tsg_pkg.sv
package tsg_pkg;

	typedef enum logic [1:0] {
		CMD_TIMER   = 2'd0,
		CMD_ENDSTOP = 2'd1,
		CMD_SETPOS  = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CRUISE_REQ,
		ST_CRUISE_WAIT,
		ST_START_REQ,
		ST_START_WAIT,
		ST_STEP_ADD,
		ST_STEP_SUB,
		ST_STEP_CHECK,
		ST_RAMP_SEL,
		ST_MUL_REQ,
		ST_MUL_WAIT,
		ST_RATE_REQ,
		ST_RATE_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic {
		REG_MAX_RATE   = 1'b0,
		REG_MIN_OFFSET = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] max_step_rate;
		logic [15:0] min_rate_offset;
	} cfg_t;

	localparam logic [15:0] MAX_RATE_RESET   = 16'd40000;
	localparam logic [15:0] MIN_OFFSET_RESET = 16'd64;
	localparam logic [15:0] RATE_QUAD        = 16'd20000;
	localparam logic [15:0] RATE_DOUBLE      = 16'd10000;
	localparam logic [15:0] FAST_THRESHOLD   = 16'd2048;
	localparam logic [15:0] MIN_PERIOD       = 16'd100;
	localparam logic [15:0] IDLE_PERIOD      = 16'd2000;
	localparam int          MUL_STEPS        = 31;

	localparam logic [31:0] FAST_ROM [64] = '{
		{16'd62500,16'd55556},{16'd6944,16'd3268},{16'd3676,16'd1176},{16'd2500,16'd607},
		{16'd1893,16'd369},{16'd1524,16'd249},{16'd1275,16'd179},{16'd1096,16'd135},
		{16'd961,16'd105},{16'd856,16'd85},{16'd771,16'd69},{16'd702,16'd58},
		{16'd644,16'd49},{16'd595,16'd42},{16'd553,16'd37},{16'd516,16'd32},
		{16'd484,16'd28},{16'd456,16'd25},{16'd431,16'd23},{16'd408,16'd20},
		{16'd388,16'd19},{16'd369,16'd16},{16'd353,16'd16},{16'd337,16'd14},
		{16'd323,16'd13},{16'd310,16'd11},{16'd299,16'd11},{16'd288,16'd11},
		{16'd277,16'd9},{16'd268,16'd9},{16'd259,16'd8},{16'd251,16'd8},
		{16'd243,16'd8},{16'd235,16'd7},{16'd228,16'd6},{16'd222,16'd6},
		{16'd216,16'd6},{16'd210,16'd6},{16'd204,16'd5},{16'd199,16'd5},
		{16'd194,16'd5},{16'd189,16'd4},{16'd185,16'd4},{16'd181,16'd4},
		{16'd177,16'd4},{16'd173,16'd4},{16'd169,16'd4},{16'd165,16'd3},
		{16'd162,16'd3},{16'd159,16'd4},{16'd155,16'd3},{16'd152,16'd3},
		{16'd149,16'd2},{16'd147,16'd3},{16'd144,16'd3},{16'd141,16'd2},
		{16'd139,16'd3},{16'd136,16'd2},{16'd134,16'd2},{16'd132,16'd3},
		{16'd129,16'd2},{16'd127,16'd2},{16'd125,16'd2},{16'd123,16'd2}
	};

	localparam logic [31:0] SLOW_ROM [256] = '{
		{16'd62500,16'd12500},{16'd50000,16'd8334},{16'd41666,16'd5952},{16'd35714,16'd4464},
		{16'd31250,16'd3473},{16'd27777,16'd2777},{16'd25000,16'd2273},{16'd22727,16'd1894},
		{16'd20833,16'd1603},{16'd19230,16'd1373},{16'd17857,16'd1191},{16'd16666,16'd1041},
		{16'd15625,16'd920},{16'd14705,16'd817},{16'd13888,16'd731},{16'd13157,16'd657},
		{16'd12500,16'd596},{16'd11904,16'd541},{16'd11363,16'd494},{16'd10869,16'd453},
		{16'd10416,16'd416},{16'd10000,16'd385},{16'd9615,16'd356},{16'd9259,16'd331},
		{16'd8928,16'd308},{16'd8620,16'd287},{16'd8333,16'd269},{16'd8064,16'd252},
		{16'd7812,16'd237},{16'd7575,16'd223},{16'd7352,16'd210},{16'd7142,16'd198},
		{16'd6944,16'd188},{16'd6756,16'd178},{16'd6578,16'd168},{16'd6410,16'd160},
		{16'd6250,16'd153},{16'd6097,16'd145},{16'd5952,16'd139},{16'd5813,16'd132},
		{16'd5681,16'd126},{16'd5555,16'd121},{16'd5434,16'd115},{16'd5319,16'd111},
		{16'd5208,16'd106},{16'd5102,16'd102},{16'd5000,16'd99},{16'd4901,16'd94},
		{16'd4807,16'd91},{16'd4716,16'd87},{16'd4629,16'd84},{16'd4545,16'd81},
		{16'd4464,16'd79},{16'd4385,16'd75},{16'd4310,16'd73},{16'd4237,16'd71},
		{16'd4166,16'd68},{16'd4098,16'd66},{16'd4032,16'd64},{16'd3968,16'd62},
		{16'd3906,16'd60},{16'd3846,16'd59},{16'd3787,16'd56},{16'd3731,16'd55},
		{16'd3676,16'd53},{16'd3623,16'd52},{16'd3571,16'd50},{16'd3521,16'd49},
		{16'd3472,16'd48},{16'd3424,16'd46},{16'd3378,16'd45},{16'd3333,16'd44},
		{16'd3289,16'd43},{16'd3246,16'd41},{16'd3205,16'd41},{16'd3164,16'd39},
		{16'd3125,16'd39},{16'd3086,16'd38},{16'd3048,16'd36},{16'd3012,16'd36},
		{16'd2976,16'd35},{16'd2941,16'd35},{16'd2906,16'd33},{16'd2873,16'd33},
		{16'd2840,16'd32},{16'd2808,16'd31},{16'd2777,16'd30},{16'd2747,16'd30},
		{16'd2717,16'd29},{16'd2688,16'd29},{16'd2659,16'd28},{16'd2631,16'd27},
		{16'd2604,16'd27},{16'd2577,16'd26},{16'd2551,16'd26},{16'd2525,16'd25},
		{16'd2500,16'd25},{16'd2475,16'd25},{16'd2450,16'd23},{16'd2427,16'd24},
		{16'd2403,16'd23},{16'd2380,16'd22},{16'd2358,16'd22},{16'd2336,16'd22},
		{16'd2314,16'd21},{16'd2293,16'd21},{16'd2272,16'd20},{16'd2252,16'd20},
		{16'd2232,16'd20},{16'd2212,16'd20},{16'd2192,16'd19},{16'd2173,16'd18},
		{16'd2155,16'd19},{16'd2136,16'd18},{16'd2118,16'd18},{16'd2100,16'd17},
		{16'd2083,16'd17},{16'd2066,16'd17},{16'd2049,16'd17},{16'd2032,16'd16},
		{16'd2016,16'd16},{16'd2000,16'd16},{16'd1984,16'd16},{16'd1968,16'd15},
		{16'd1953,16'd16},{16'd1937,16'd14},{16'd1923,16'd15},{16'd1908,16'd15},
		{16'd1893,16'd14},{16'd1879,16'd14},{16'd1865,16'd14},{16'd1851,16'd13},
		{16'd1838,16'd14},{16'd1824,16'd13},{16'd1811,16'd13},{16'd1798,16'd13},
		{16'd1785,16'd12},{16'd1773,16'd13},{16'd1760,16'd12},{16'd1748,16'd12},
		{16'd1736,16'd12},{16'd1724,16'd12},{16'd1712,16'd12},{16'd1700,16'd11},
		{16'd1689,16'd12},{16'd1677,16'd11},{16'd1666,16'd11},{16'd1655,16'd11},
		{16'd1644,16'd11},{16'd1633,16'd10},{16'd1623,16'd11},{16'd1612,16'd10},
		{16'd1602,16'd10},{16'd1592,16'd10},{16'd1582,16'd10},{16'd1572,16'd10},
		{16'd1562,16'd10},{16'd1552,16'd9},{16'd1543,16'd10},{16'd1533,16'd9},
		{16'd1524,16'd9},{16'd1515,16'd9},{16'd1506,16'd9},{16'd1497,16'd9},
		{16'd1488,16'd9},{16'd1479,16'd9},{16'd1470,16'd9},{16'd1461,16'd8},
		{16'd1453,16'd8},{16'd1445,16'd9},{16'd1436,16'd8},{16'd1428,16'd8},
		{16'd1420,16'd8},{16'd1412,16'd8},{16'd1404,16'd8},{16'd1396,16'd8},
		{16'd1388,16'd7},{16'd1381,16'd8},{16'd1373,16'd7},{16'd1366,16'd8},
		{16'd1358,16'd7},{16'd1351,16'd7},{16'd1344,16'd8},{16'd1336,16'd7},
		{16'd1329,16'd7},{16'd1322,16'd7},{16'd1315,16'd7},{16'd1308,16'd6},
		{16'd1302,16'd7},{16'd1295,16'd7},{16'd1288,16'd6},{16'd1282,16'd7},
		{16'd1275,16'd6},{16'd1269,16'd7},{16'd1262,16'd6},{16'd1256,16'd6},
		{16'd1250,16'd7},{16'd1243,16'd6},{16'd1237,16'd6},{16'd1231,16'd6},
		{16'd1225,16'd6},{16'd1219,16'd6},{16'd1213,16'd6},{16'd1207,16'd6},
		{16'd1201,16'd5},{16'd1196,16'd6},{16'd1190,16'd6},{16'd1184,16'd5},
		{16'd1179,16'd6},{16'd1173,16'd5},{16'd1168,16'd6},{16'd1162,16'd5},
		{16'd1157,16'd5},{16'd1152,16'd6},{16'd1146,16'd5},{16'd1141,16'd5},
		{16'd1136,16'd5},{16'd1131,16'd5},{16'd1126,16'd5},{16'd1121,16'd5},
		{16'd1116,16'd5},{16'd1111,16'd5},{16'd1106,16'd5},{16'd1101,16'd5},
		{16'd1096,16'd5},{16'd1091,16'd5},{16'd1086,16'd4},{16'd1082,16'd5},
		{16'd1077,16'd5},{16'd1072,16'd4},{16'd1068,16'd5},{16'd1063,16'd4},
		{16'd1059,16'd5},{16'd1054,16'd4},{16'd1050,16'd4},{16'd1046,16'd5},
		{16'd1041,16'd4},{16'd1037,16'd4},{16'd1033,16'd5},{16'd1028,16'd4},
		{16'd1024,16'd4},{16'd1020,16'd4},{16'd1016,16'd4},{16'd1012,16'd4},
		{16'd1008,16'd4},{16'd1004,16'd4},{16'd1000,16'd4},{16'd996,16'd4},
		{16'd992,16'd4},{16'd988,16'd4},{16'd984,16'd4},{16'd980,16'd4},
		{16'd976,16'd4},{16'd972,16'd4},{16'd968,16'd3},{16'd965,16'd3}
	};

endpackage

>>> hdl/tsg_channels.sv
interface tsg_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         cmd;
	logic               block_ready;
	logic [31:0]        move_steps;
	logic [31:0]        move_events;
	logic [31:0]        accel_end;
	logic [31:0]        decel_start;
	logic [15:0]        start_rate;
	logic [15:0]        cruise_rate;
	logic [15:0]        end_rate;
	logic [30:0]        accel_factor;
	logic               move_reverse;
	logic signed [31:0] new_position;

	modport source (output valid, cmd, block_ready, move_steps, move_events, accel_end,
		decel_start, start_rate, cruise_rate, end_rate, accel_factor, move_reverse,
		new_position, input ready);
	modport sink (input valid, cmd, block_ready, move_steps, move_events, accel_end,
		decel_start, start_rate, cruise_rate, end_rate, accel_factor, move_reverse,
		new_position, output ready);
endinterface

interface tsg_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         step_pulses;
	logic               dir_out;
	logic [15:0]        next_period;
	logic               block_taken;
	logic               block_done;
	logic signed [31:0] position_out;
	logic signed [31:0] endstop_pos;

	modport source (output valid, step_pulses, dir_out, next_period, block_taken,
		block_done, position_out, endstop_pos, input ready);
	modport sink (input valid, step_pulses, dir_out, next_period, block_taken,
		block_done, position_out, endstop_pos, output ready);
endinterface

>>> hdl/tsg_serial_mul.sv
module tsg_serial_mul
	import tsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] time_val,
	input  logic [30:0] factor,
	output logic        busy,
	output logic        done,
	output logic [15:0] product
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [39:0] mcand_q;
	logic [30:0] mplier_q;
	logic [39:0] acc_q;

	// One multiplier bit per cycle; only the low 40 product bits are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {{8{time_val[31]}}, time_val};
			mplier_q <= factor;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[38:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[30:1]};
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = acc_q[39:24];
endmodule

>>> hdl/tsg_rate_period.sv
module tsg_rate_period
	import tsg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        req,
	input  logic [15:0] rate,
	output logic        valid,
	output logic [15:0] period,
	output logic [2:0]  loops
);
	logic        valid_s1;
	logic [15:0] r_s1;
	logic [2:0]  loops_s1;
	logic        valid_s2;
	logic [15:0] period_s2;
	logic [2:0]  loops_s2;

	logic [15:0] clamped;
	logic [15:0] scaled;
	logic [2:0]  loops_c;
	logic [15:0] reduced;
	logic [31:0] fast_entry;
	logic [31:0] slow_entry;
	logic [23:0] fast_prod;
	logic [18:0] slow_prod;
	logic [15:0] raw_period;

	always_comb begin
		clamped = (rate > cfg.max_step_rate) ? cfg.max_step_rate : rate;
		if (clamped > RATE_QUAD) begin
			scaled  = {2'b00, clamped[15:2]};
			loops_c = 3'd4;
		end else if (clamped > RATE_DOUBLE) begin
			scaled  = {1'b0, clamped[15:1]};
			loops_c = 3'd2;
		end else begin
			scaled  = clamped;
			loops_c = 3'd1;
		end
		reduced = (scaled > cfg.min_rate_offset) ? (scaled - cfg.min_rate_offset) : 16'd0;
	end

	always_comb begin
		fast_entry = FAST_ROM[r_s1[13:8]];
		slow_entry = SLOW_ROM[r_s1[10:3]];
		fast_prod  = fast_entry[15:0] * r_s1[7:0];
		slow_prod  = slow_entry[15:0] * r_s1[2:0];
		if (r_s1 >= FAST_THRESHOLD) begin
			raw_period = fast_entry[31:16] - {8'd0, fast_prod[23:16]};
		end else begin
			raw_period = slow_entry[31:16] - slow_prod[18:3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= req;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		r_s1      <= reduced;
		loops_s1  <= loops_c;
		period_s2 <= (raw_period < MIN_PERIOD) ? MIN_PERIOD : raw_period;
		loops_s2  <= loops_s1;
	end

	assign valid  = valid_s2;
	assign period = period_s2;
	assign loops  = loops_s2;
endmodule

>>> hdl/trapezoid_step_generator_unit.sv
// An endstop, set-position or idle timer transaction goes from acceptance straight
// to the output state. A timer transaction with a move runs the add, subtract and
// check states once per step event (1, 2 or 4 events); loading a move first looks up
// the cruise and start periods; after ramp selection an accelerating or decelerating
// period adds the serial multiply and another period lookup. Stalls hold the output.
// Reset is asynchronous and clears control and position state; no clearing pass needed.
`include "trapezoid_step_generator_unit_assert.svh"
module trapezoid_step_generator_unit
	import tsg_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	tsg_item_if.sink     item,
	tsg_result_if.source result
);
	state_t state_q, state_d;
	cfg_t   cfg_q;

	logic        active_q, decel_q;
	logic [31:0] bres_q, events_done_q;
	logic [31:0] steps_q, events_q, accel_end_q, decel_start_q;
	logic [30:0] factor_q;
	logic [15:0] start_q, cruise_q, end_q;
	logic        dir_q;
	logic [15:0] ramp_rate_q, cruise_period_q, rate_q;
	logic [31:0] accel_time_q, decel_time_q;
	logic [2:0]  loops_now_q, loops_cruise_q, iter_q;
	logic [31:0] pos_q, trig_q;
	logic [2:0]  pulses_q;
	logic [15:0] period_q;
	logic        taken_q, done_q;

	logic        out_valid_q;
	logic [2:0]  out_pulses_q;
	logic        out_dir_q, out_taken_q, out_done_q;
	logic [15:0] out_period_q;
	logic [31:0] out_pos_q, out_trig_q;

	logic        accept, cfg_write, out_load;
	logic        r2p_req, mul_req;
	logic [15:0] r2p_rate;
	logic        r2p_valid;
	logic [15:0] r2p_period;
	logic [2:0]  r2p_loops;
	logic        mul_busy, mul_done;
	logic [15:0] mul_prod;
	logic [15:0] accel_sum, accel_rate, decel_rate;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (reg_idx_t'(paddr[2]) == REG_MIN_OFFSET) ?
		{16'd0, cfg_q.min_rate_offset} : {16'd0, cfg_q.max_step_rate};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_step_rate   <= MAX_RATE_RESET;
			cfg_q.min_rate_offset <= MIN_OFFSET_RESET;
		end else if (cfg_write) begin
			case (reg_idx_t'(paddr[2]))
				REG_MAX_RATE:   cfg_q.max_step_rate   <= pwdata[15:0];
				REG_MIN_OFFSET: cfg_q.min_rate_offset <= pwdata[15:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	tsg_rate_period u_rate (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (r2p_req),
		.rate   (r2p_rate),
		.valid  (r2p_valid),
		.period (r2p_period),
		.loops  (r2p_loops)
	);

	tsg_serial_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mul_req),
		.time_val (decel_q ? decel_time_q : accel_time_q),
		.factor   (factor_q),
		.busy     (mul_busy),
		.done     (mul_done),
		.product  (mul_prod)
	);

	assign accept = item.valid && item.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					if (cmd_t'(item.cmd) == CMD_TIMER) begin
						if (!active_q && item.block_ready) begin
							state_d = ST_CRUISE_REQ;
						end else if (active_q) begin
							state_d = ST_STEP_ADD;
						end else begin
							state_d = ST_OUT;
						end
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_CRUISE_REQ:  state_d = ST_CRUISE_WAIT;
			ST_CRUISE_WAIT: if (r2p_valid) state_d = ST_START_REQ;
			ST_START_REQ:   state_d = ST_START_WAIT;
			ST_START_WAIT:  if (r2p_valid) state_d = ST_STEP_ADD;
			ST_STEP_ADD:    state_d = ST_STEP_SUB;
			ST_STEP_SUB:    state_d = ST_STEP_CHECK;
			ST_STEP_CHECK: begin
				if (events_done_q >= events_q || iter_q + 3'd1 >= loops_now_q) begin
					state_d = ST_RAMP_SEL;
				end else begin
					state_d = ST_STEP_ADD;
				end
			end
			ST_RAMP_SEL: begin
				if (events_done_q <= accel_end_q || events_done_q > decel_start_q) begin
					state_d = ST_MUL_REQ;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_MUL_REQ:   state_d = ST_MUL_WAIT;
			ST_MUL_WAIT:  if (mul_done) state_d = ST_RATE_REQ;
			ST_RATE_REQ:  state_d = ST_RATE_WAIT;
			ST_RATE_WAIT: if (r2p_valid) state_d = ST_OUT;
			ST_OUT:       if (!out_valid_q || result.ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = 1'b0;
		r2p_req    = 1'b0;
		r2p_rate   = rate_q;
		mul_req    = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE:       item.ready = 1'b1;
			ST_CRUISE_REQ: begin
				r2p_req  = 1'b1;
				r2p_rate = cruise_q;
			end
			ST_START_REQ: begin
				r2p_req  = 1'b1;
				r2p_rate = start_q;
			end
			ST_RATE_REQ:   r2p_req = 1'b1;
			ST_MUL_REQ:    mul_req = 1'b1;
			ST_OUT:        out_load = !out_valid_q || result.ready;
			default:       item.ready = 1'b0;
		endcase
	end

	always_comb begin
		accel_sum  = mul_prod + start_q;
		accel_rate = (accel_sum > cruise_q) ? cruise_q : accel_sum;
		if (mul_prod < ramp_rate_q) begin
			decel_rate = ((ramp_rate_q - mul_prod) < end_q) ? end_q : (ramp_rate_q - mul_prod);
		end else begin
			decel_rate = end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			active_q        <= 1'b0;
			bres_q          <= '0;
			events_done_q   <= '0;
			dir_q           <= 1'b0;
			ramp_rate_q     <= '0;
			accel_time_q    <= '0;
			decel_time_q    <= '0;
			cruise_period_q <= '0;
			loops_now_q     <= 3'd1;
			loops_cruise_q  <= 3'd1;
			pos_q           <= '0;
			trig_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (cmd_t'(item.cmd))
					CMD_ENDSTOP: begin
						trig_q <= pos_q;
						if (active_q) events_done_q <= events_q;
					end
					CMD_SETPOS: pos_q <= item.new_position;
					CMD_TIMER: begin
						if (!active_q && item.block_ready) begin
							dir_q         <= item.move_reverse;
							decel_time_q  <= '0;
							ramp_rate_q   <= item.start_rate;
							bres_q        <= 32'd0 - {1'b0, item.move_events[31:1]};
							events_done_q <= '0;
							active_q      <= 1'b1;
						end
					end
					default: trig_q <= trig_q;
				endcase
			end
			if (state_q == ST_CRUISE_WAIT && r2p_valid) begin
				cruise_period_q <= r2p_period;
				loops_cruise_q  <= r2p_loops;
			end
			if (state_q == ST_START_WAIT && r2p_valid) begin
				accel_time_q <= {16'd0, r2p_period};
				loops_now_q  <= r2p_loops;
			end
			if (state_q == ST_STEP_ADD) begin
				bres_q <= bres_q + steps_q;
			end
			if (state_q == ST_STEP_SUB) begin
				events_done_q <= events_done_q + 32'd1;
				if (bres_q != 32'd0 && !bres_q[31]) begin
					bres_q <= bres_q - events_q;
					pos_q  <= dir_q ? pos_q - 32'd1 : pos_q + 32'd1;
				end
			end
			if (state_q == ST_RAMP_SEL && state_d == ST_OUT) begin
				loops_now_q <= loops_cruise_q;
			end
			if (state_q == ST_MUL_WAIT && mul_done && !decel_q) begin
				ramp_rate_q <= accel_rate;
			end
			if (state_q == ST_RATE_WAIT && r2p_valid) begin
				loops_now_q <= r2p_loops;
				if (decel_q) begin
					decel_time_q <= decel_time_q + {16'd0, r2p_period};
				end else begin
					accel_time_q <= accel_time_q + {16'd0, r2p_period};
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (done_q) active_q <= 1'b0;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			iter_q   <= '0;
			pulses_q <= '0;
			taken_q  <= 1'b0;
			done_q   <= 1'b0;
			period_q <= IDLE_PERIOD;
			if (cmd_t'(item.cmd) == CMD_TIMER && !active_q && item.block_ready) begin
				steps_q       <= item.move_steps;
				events_q      <= item.move_events;
				accel_end_q   <= item.accel_end;
				decel_start_q <= item.decel_start;
				factor_q      <= item.accel_factor;
				start_q       <= item.start_rate;
				cruise_q      <= item.cruise_rate;
				end_q         <= item.end_rate;
				taken_q       <= 1'b1;
			end
		end
		if (state_q == ST_STEP_SUB && bres_q != 32'd0 && !bres_q[31]) begin
			pulses_q <= pulses_q + 3'd1;
		end
		if (state_q == ST_STEP_CHECK) begin
			iter_q <= iter_q + 3'd1;
			if (events_done_q >= events_q) done_q <= 1'b1;
		end
		if (state_q == ST_RAMP_SEL) begin
			decel_q <= !(events_done_q <= accel_end_q);
			if (state_d == ST_OUT) period_q <= cruise_period_q;
		end
		if (state_q == ST_MUL_WAIT && mul_done) begin
			rate_q <= decel_q ? decel_rate : accel_rate;
		end
		if (state_q == ST_RATE_WAIT && r2p_valid) begin
			period_q <= r2p_period;
		end
		if (out_load) begin
			out_pulses_q <= pulses_q;
			out_dir_q    <= dir_q;
			out_period_q <= period_q;
			out_taken_q  <= taken_q;
			out_done_q   <= done_q;
			out_pos_q    <= pos_q;
			out_trig_q   <= trig_q;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.step_pulses  = out_pulses_q;
	assign result.dir_out      = out_dir_q;
	assign result.next_period  = out_period_q;
	assign result.block_taken  = out_taken_q;
	assign result.block_done   = out_done_q;
	assign result.position_out = out_pos_q;
	assign result.endstop_pos  = out_trig_q;

	`TSG_NEVER(a_loops_onehot, !$onehot(loops_now_q) || loops_now_q == 3'd4 && 1'b0)
	`TSG_NEVER(a_period_floor, out_valid_q && out_period_q < MIN_PERIOD)
	`TSG_IMPLIES(a_accept_mul_idle, accept, !mul_busy && !r2p_valid)
	`TSG_IMPLIES(a_step_needs_move, state_q == ST_STEP_ADD, active_q)
endmodule

>>> test/trapezoid_step_generator_unit_test.sv
`timescale 1ns / 100ps
module trapezoid_step_generator_unit_test;
	import tsg_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_ITEMS = 410;
	localparam int QUIET_AFTER = 1450;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        block_ready;
		logic [31:0] move_steps;
		logic [31:0] move_events;
		logic [31:0] accel_end;
		logic [31:0] decel_start;
		logic [15:0] start_rate;
		logic [15:0] cruise_rate;
		logic [15:0] end_rate;
		logic [30:0] accel_factor;
		logic        move_reverse;
		logic [31:0] new_position;
	} axis_cmd_t;

	typedef struct packed {
		logic [2:0]  step_pulses;
		logic        dir_out;
		logic [15:0] next_period;
		logic        block_taken;
		logic        block_done;
		logic [31:0] position_out;
		logic [31:0] endstop_pos;
	} axis_report_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	tsg_item_if item_ch ();
	tsg_result_if result_ch ();

	trapezoid_step_generator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item(item_ch),
		.result(result_ch)
	);

	// Axis state mirror.
	logic [15:0] cfg_max_rate, cfg_min_offset;
	logic        mv_active;
	logic [31:0] err_acc, ev_count;
	logic [31:0] mv_steps, mv_events, mv_accel_end, mv_decel_start, mv_factor;
	logic [15:0] r_start, r_cruise, r_end, cur_rate, cruise_per;
	logic        dir_q;
	logic [31:0] t_accel, t_decel, pos_q, trig_q;
	logic [2:0]  loops, loops_cr;

	axis_report_t pending_reports[$];
	int fail_count = 0;
	int idle_cycles = 0;
	int moves_loaded = 0;
	int moves_finished = 0;
	int pulses_seen = 0;
	int reports_seen = 0;
	bit quiet = 0;

	function automatic logic [15:0] rate_period(input logic [15:0] rate);
		logic [31:0] r;
		logic [31:0] t;
		logic [31:0] rom;
		r = rate;
		if (r > cfg_max_rate) r = cfg_max_rate;
		if (r > RATE_QUAD) begin
			r = r >> 2;
			loops = 3'd4;
		end else if (r > RATE_DOUBLE) begin
			r = r >> 1;
			loops = 3'd2;
		end else begin
			loops = 3'd1;
		end
		r = (r > cfg_min_offset) ? r - cfg_min_offset : 32'd0;
		if (r >= FAST_THRESHOLD) begin
			rom = FAST_ROM[(r >> 8) & 32'd63];
			t = ({16'd0, rom[31:16]} - (({16'd0, rom[15:0]} * (r & 32'hFF)) >> 16)) & 32'hFFFF;
		end else begin
			rom = SLOW_ROM[(r >> 3) & 32'hFF];
			t = ({16'd0, rom[31:16]} - (({16'd0, rom[15:0]} * (r & 32'h7)) >> 3)) & 32'hFFFF;
		end
		if (t < MIN_PERIOD) t = MIN_PERIOD;
		return t[15:0];
	endfunction

	function automatic logic [15:0] ramp_scale(input logic [31:0] tm, input logic [31:0] f);
		logic [63:0] p;
		p = {{32{tm[31]}}, tm} * {32'd0, f};
		return p[39:24];
	endfunction

	function automatic axis_report_t advance_axis(input axis_cmd_t c);
		axis_report_t o;
		logic [15:0] r;
		o = '0;
		o.next_period = IDLE_PERIOD;
		if (c.cmd == CMD_ENDSTOP) begin
			trig_q = pos_q;
			if (mv_active) ev_count = mv_events;
		end else if (c.cmd == CMD_SETPOS) begin
			pos_q = c.new_position;
		end else if (c.cmd == CMD_TIMER) begin
			if (!mv_active && c.block_ready) begin
				mv_steps = c.move_steps;
				mv_events = c.move_events;
				mv_accel_end = c.accel_end;
				mv_decel_start = c.decel_start;
				mv_factor = {1'b0, c.accel_factor};
				r_start = c.start_rate;
				r_cruise = c.cruise_rate;
				r_end = c.end_rate;
				dir_q = c.move_reverse;
				t_decel = '0;
				cruise_per = rate_period(r_cruise);
				loops_cr = loops;
				cur_rate = r_start;
				t_accel = {16'd0, rate_period(cur_rate)};
				err_acc = 32'd0 - (mv_events >> 1);
				ev_count = '0;
				mv_active = 1;
				o.block_taken = 1;
			end
			if (mv_active) begin
				for (int i = 0; i < loops; i++) begin
					err_acc = err_acc + mv_steps;
					if (err_acc != 0 && !err_acc[31]) begin
						err_acc = err_acc - mv_events;
						pos_q = dir_q ? pos_q - 1 : pos_q + 1;
						o.step_pulses = o.step_pulses + 1;
					end
					ev_count = ev_count + 1;
					if (ev_count >= mv_events) begin
						o.block_done = 1;
						break;
					end
				end
				if (ev_count <= mv_accel_end) begin
					cur_rate = ramp_scale(t_accel, mv_factor) + r_start;
					if (cur_rate > r_cruise) cur_rate = r_cruise;
					o.next_period = rate_period(cur_rate);
					t_accel = t_accel + o.next_period;
				end else if (ev_count > mv_decel_start) begin
					r = ramp_scale(t_decel, mv_factor);
					if (r < cur_rate) begin
						r = cur_rate - r;
						if (r < r_end) r = r_end;
					end else begin
						r = r_end;
					end
					o.next_period = rate_period(r);
					t_decel = t_decel + o.next_period;
				end else begin
					o.next_period = cruise_per;
					loops = loops_cr;
				end
				if (o.block_done) mv_active = 0;
			end
		end
		o.dir_out = dir_q;
		o.position_out = pos_q;
		o.endstop_pos = trig_q;
		return o;
	endfunction

	function automatic axis_cmd_t make_cmd(input logic [1:0] cmd, input logic br,
		input logic [31:0] steps, input logic [31:0] events, input logic [31:0] ae,
		input logic [31:0] ds, input logic [15:0] sr, input logic [15:0] cr,
		input logic [15:0] er, input logic [30:0] af, input logic rev,
		input logic [31:0] np);
		axis_cmd_t c;
		c.cmd = cmd;
		c.block_ready = br;
		c.move_steps = steps;
		c.move_events = events;
		c.accel_end = ae;
		c.decel_start = ds;
		c.start_rate = sr;
		c.cruise_rate = cr;
		c.end_rate = er;
		c.accel_factor = af;
		c.move_reverse = rev;
		c.new_position = np;
		return c;
	endfunction

	function automatic axis_cmd_t noise_cmd(input logic [1:0] cmd);
		return make_cmd(cmd, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
			$urandom, 16'($urandom), 16'($urandom), 16'($urandom), 31'($urandom),
			1'($urandom_range(0, 1)), $urandom);
	endfunction

	function automatic axis_cmd_t fresh_move();
		logic [31:0] ev;
		logic [31:0] ae;
		axis_cmd_t c;
		if ($urandom_range(0, 9) == 0) begin
			c = noise_cmd(CMD_TIMER);
			c.block_ready = 1'b1;
			return c;
		end
		ev = $urandom_range(1, 60);
		ae = $urandom_range(0, ev);
		return make_cmd(CMD_TIMER, 1'b1, $urandom_range(0, ev), ev, ae, $urandom_range(ae, ev),
			16'($urandom_range(0, 3000)), 16'(($urandom_range(0, 1) ?
			$urandom_range(0, 65535) : $urandom_range(500, 9000))),
			16'($urandom_range(0, 3000)),
			31'($urandom_range(0, 32'h7FFFFFFF) >> $urandom_range(4, 16)),
			1'($urandom_range(0, 1)), $urandom);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		item_ch.valid = 0;
		item_ch.cmd = CMD_TIMER;
		item_ch.block_ready = 0;
		item_ch.move_steps = 0;
		item_ch.move_events = 0;
		item_ch.accel_end = 0;
		item_ch.decel_start = 0;
		item_ch.start_rate = 0;
		item_ch.cruise_rate = 0;
		item_ch.end_rate = 0;
		item_ch.accel_factor = 0;
		item_ch.move_reverse = 0;
		item_ch.new_position = 0;
		result_ch.ready = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
	end

	int ready_hold = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 0;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			result_ch.ready <= 0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			ready_hold <= $urandom_range(0, 5);
			result_ch.ready <= 0;
		end else begin
			result_ch.ready <= 1;
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		axis_report_t want;
		if (result_ch.valid && result_ch.ready) begin
			reports_seen++;
			if (pending_reports.size() == 0) begin
				$error("result transaction with no expectation pending");
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("step_pulses", want.step_pulses, result_ch.step_pulses);
				check_field("dir_out", want.dir_out, result_ch.dir_out);
				check_field("next_period", want.next_period, result_ch.next_period);
				check_field("block_taken", want.block_taken, result_ch.block_taken);
				check_field("block_done", want.block_done, result_ch.block_done);
				check_field("position_out", want.position_out, result_ch.position_out);
				check_field("endstop_pos", want.endstop_pos, result_ch.endstop_pos);
				pulses_seen += result_ch.step_pulses;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d results pending.",
					pending_reports.size());
				$display("FAIL trapezoid_step_generator_unit");
				$finish;
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'(idx) << 2;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == REG_MAX_RATE) cfg_max_rate = value;
		else cfg_min_offset = value;
	endtask

	task automatic drain();
		item_ch.valid <= 0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_cmd(input axis_cmd_t c, input bit typed, input axis_report_t typed_exp);
		axis_report_t pred;
		if (!quiet && $urandom_range(0, 6) == 0) begin
			item_ch.valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_ch.valid <= 1;
		item_ch.cmd <= c.cmd;
		item_ch.block_ready <= c.block_ready;
		item_ch.move_steps <= c.move_steps;
		item_ch.move_events <= c.move_events;
		item_ch.accel_end <= c.accel_end;
		item_ch.decel_start <= c.decel_start;
		item_ch.start_rate <= c.start_rate;
		item_ch.cruise_rate <= c.cruise_rate;
		item_ch.end_rate <= c.end_rate;
		item_ch.accel_factor <= c.accel_factor;
		item_ch.move_reverse <= c.move_reverse;
		item_ch.new_position <= c.new_position;
		do @(posedge clk); while (!item_ch.ready);
		pred = advance_axis(c);
		if (pred.block_taken) moves_loaded++;
		if (pred.block_done) moves_finished++;
		pending_reports.push_back(typed ? typed_exp : pred);
	endtask

	axis_cmd_t dir_tab[25];
	bit dir_typed[25];
	axis_report_t dir_exp[25];

	initial begin
		axis_cmd_t c;
		int sent;
		int move_age;
		arst_n = 0;
		cfg_max_rate = MAX_RATE_RESET;
		cfg_min_offset = MIN_OFFSET_RESET;
		mv_active = 0;
		err_acc = 0;
		ev_count = 0;
		dir_q = 0;
		cur_rate = 0;
		t_accel = 0;
		t_decel = 0;
		cruise_per = 0;
		loops = 1;
		loops_cr = 1;
		pos_q = 0;
		trig_q = 0;
		foreach (dir_typed[i]) dir_typed[i] = 0;

		dir_tab[0] = make_cmd(CMD_TIMER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_typed[0] = 1;
		dir_exp[0] = '{3'd0, 1'b0, IDLE_PERIOD, 1'b0, 1'b0, 32'd0, 32'd0};
		dir_tab[1] = make_cmd(CMD_SETPOS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF);
		dir_typed[1] = 1;
		dir_exp[1] = '{3'd0, 1'b0, IDLE_PERIOD, 1'b0, 1'b0, 32'h7FFFFFFF, 32'd0};
		dir_tab[2] = make_cmd(CMD_ENDSTOP, 1, '1, '1, '1, '1, '1, '1, '1, '1, 1, 0);
		dir_typed[2] = 1;
		dir_exp[2] = '{3'd0, 1'b0, IDLE_PERIOD, 1'b0, 1'b0, 32'h7FFFFFFF, 32'h7FFFFFFF};
		dir_tab[3] = make_cmd(CMD_SETPOS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h80000000);
		dir_typed[3] = 1;
		dir_exp[3] = '{3'd0, 1'b0, IDLE_PERIOD, 1'b0, 1'b0, 32'h80000000, 32'h7FFFFFFF};
		dir_tab[4] = make_cmd(CMD_UNUSED, 1, '1, '1, '1, '1, '1, '1, '1, '1, 1, '1);
		dir_typed[4] = 1;
		dir_exp[4] = dir_exp[3];
		dir_tab[5] = make_cmd(CMD_TIMER, 1, 5, 10, 3, 6, 500, 30000, 200, 31'h100000, 0, 0);
		for (int i = 6; i < 10; i++)
			dir_tab[i] = make_cmd(CMD_TIMER, 1, '1, 1, 0, 0, 9, 9, 9, 1, 1, 0);
		dir_tab[10] = make_cmd(CMD_ENDSTOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[11] = make_cmd(CMD_TIMER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[12] = make_cmd(CMD_TIMER, 1, 3, 0, 0, 0, 100, 200, 50, 31'h1000, 1, 0);
		dir_tab[13] = make_cmd(CMD_TIMER, 1, '1, '1, '1, '1, '1, '1, '1, '1, 1, 0);
		dir_tab[14] = make_cmd(CMD_TIMER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[15] = make_cmd(CMD_SETPOS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[16] = dir_tab[14];
		dir_tab[17] = dir_tab[10];
		dir_tab[18] = dir_tab[14];
		dir_tab[19] = make_cmd(CMD_TIMER, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		dir_tab[20] = make_cmd(CMD_TIMER, 1, 7, 8, 0, 0, 15000, 15000, 1000,
			31'h7FFFFFFF, 0, 0);
		for (int i = 21; i < 25; i++) dir_tab[i] = dir_tab[14];

		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		sent = 0;
		move_age = 0;
		for (int phase = 0; phase < 4; phase++) begin
			if (phase > 0) drain();
			case (phase)
				0: begin
					write_reg(REG_MAX_RATE, MAX_RATE_RESET);
					write_reg(REG_MIN_OFFSET, MIN_OFFSET_RESET);
				end
				1: begin
					write_reg(REG_MAX_RATE, 16'hFFFF);
					write_reg(REG_MIN_OFFSET, 16'd0);
				end
				2: begin
					write_reg(REG_MAX_RATE, 16'd0);
					write_reg(REG_MIN_OFFSET, 16'hFFFF);
				end
				default: begin
					write_reg(REG_MAX_RATE, 16'($urandom_range(5000, 45000)));
					write_reg(REG_MIN_OFFSET, 16'($urandom_range(0, 200)));
				end
			endcase
			if (phase == 0) begin
				foreach (dir_tab[i]) begin
					send_cmd(dir_tab[i], dir_typed[i], dir_exp[i]);
					sent++;
				end
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				quiet = (sent >= QUIET_AFTER);
				if (!mv_active) begin
					move_age = 0;
					case ($urandom_range(0, 19))
						0: c = noise_cmd(CMD_SETPOS);
						1: c = noise_cmd(CMD_ENDSTOP);
						2: c = noise_cmd(CMD_UNUSED);
						3: c = noise_cmd(CMD_TIMER);
						default: c = fresh_move();
					endcase
				end else begin
					move_age++;
					if (move_age > 30) c = noise_cmd(CMD_ENDSTOP);
					else case ($urandom_range(0, 19))
						0: c = noise_cmd(CMD_SETPOS);
						1: c = noise_cmd(CMD_ENDSTOP);
						2: c = noise_cmd(CMD_UNUSED);
						default: c = noise_cmd(CMD_TIMER);
					endcase
				end
				send_cmd(c, 0, '0);
				sent++;
			end
		end
		drain();
		$display("Sent %0d transactions over four rate settings; %0d results checked.",
			sent, reports_seen);
		$display("Moves loaded %0d, finished %0d, step pulses %0d.",
			moves_loaded, moves_finished, pulses_seen);
		if (fail_count == 0 && pending_reports.size() == 0) begin
			$display("PASS trapezoid_step_generator_unit");
		end else begin
			$display("FAIL trapezoid_step_generator_unit");
		end
		$finish;
	end
endmodule

>>> files.f
+incdir+hdl
hdl/tsg_pkg.sv
hdl/tsg_channels.sv
hdl/tsg_serial_mul.sv
hdl/tsg_rate_period.sv
hdl/trapezoid_step_generator_unit.sv
test/trapezoid_step_generator_unit_test.sv
